// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ping/light note event generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define PLNE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define PLNE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/plne_pkg.sv -----
// ----------------------------------------------------------------------------
// plne_pkg
// Types, constants and codes for the ping/light note event generator.
// ----------------------------------------------------------------------------
package plne_pkg;

    localparam int MAX_ROUNDS_DEF = 16;

    localparam int DIST_W   = 10;
    localparam int LIGHT_W  = 10;
    localparam int PPR_W    = 5;
    localparam int THR_W    = 11;
    localparam int OCT_W    = 8;
    localparam int LAST_W   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;

    localparam logic [LAST_W-1:0] NO_OCTAVE  = 9'h1FF;
    localparam logic [LAST_W-1:0] OCTAVE_CAP = 9'd254;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PINGS_PER_ROUND = 3'd0,
        REG_MIN_DISTANCE    = 3'd1,
        REG_MAX_DISTANCE    = 3'd2,
        REG_OCTAVE_SPAN     = 3'd3,
        REG_LIGHT_THRESHOLD = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [PPR_W-1:0]  pings_per_round;
        logic [DIST_W-1:0] min_distance;
        logic [DIST_W-1:0] max_distance;
        logic [DIST_W-1:0] octave_span;
        logic [THR_W-1:0]  light_threshold;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_OCT,
        S_EVAL,
        S_EMIT0,
        S_EMIT1
    } state_t;

endpackage

// ----- hw/rtl/plne_ifs.sv -----
// ----------------------------------------------------------------------------
// plne channel interfaces
// Valid/ready channels for ping samples and note events.
// ----------------------------------------------------------------------------
interface plne_ping_if
    import plne_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  echo_range;
    logic [LIGHT_W-1:0] light_raw;

    modport source (output valid, output echo_range, output light_raw, input ready);
    modport sink   (input valid, input echo_range, input light_raw, output ready);
endinterface

interface plne_note_if
    import plne_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             note_on;
    logic [OCT_W-1:0] octave;
    logic             final_res;

    modport source (output valid, output note_on, output octave, output final_res,
                    input ready);
    modport sink   (input valid, input note_on, input octave, input final_res,
                    output ready);
endinterface

// ----- hw/rtl/ping_light_note_event_generator_unit.sv -----
// ----------------------------------------------------------------------------
// ping_light_note_event_generator_unit
// Gathers sonar pings into rounds, averages them, derives an octave and
// emits note-on / note-off events from ping distance and light level.
// ----------------------------------------------------------------------------
//  channel   dir   payload                          transfer
//  ping_ch   in    echo_range[9:0], light_raw[9:0]  valid & ready
//  note_ch   out   note_on, octave[7:0], final_res  valid & ready
//  cfg       in    cfg_index[2:0], cfg_wdata[10:0]  cfg_we
//
//  A ping that does not close a round only updates the round counters.
//  A round-closing ping makes two passes through the one-bit-per-cycle
//  shared divider (average, then octave) and then moves each event into
//  the output register; a zero average skips the second pass.
//  Reset clears the round counters, activity flag and last octave (none).
//  A stalled note_ch holds the event sequencer; ping_ch stays low meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ping_light_note_event_generator_unit
    import plne_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    plne_ping_if.sink            ping_ch,
    plne_note_if.source          note_ch
);

    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);
    localparam int SUM_W = $clog2(MAX_ROUNDS * 1023 + 1);
    localparam int CMP_W = (CNT_W > PPR_W) ? CNT_W : PPR_W;
    localparam int PRD_W = SUM_W + 3;

    cfg_t cfg;

    plne_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   zero_reg, zero_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               was_active_reg, was_active_next;
    logic [LAST_W-1:0]  last_oct_reg, last_oct_next;
    logic               light_act_reg, light_act_next;
    logic               ping_act_reg, ping_act_next;
    logic [LAST_W-1:0]  oct_reg, oct_next;
    logic [1:0]         ev_cnt_reg, ev_cnt_next;
    logic               ev0_on_reg, ev0_on_next;
    logic [OCT_W-1:0]   ev0_oct_reg, ev0_oct_next;
    logic [OCT_W-1:0]   ev1_oct_reg, ev1_oct_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_on_reg, out_on_next;
    logic [OCT_W-1:0]   out_oct_reg, out_oct_next;
    logic               out_final_reg, out_final_next;

    logic               accept;
    logic               out_free;
    logic [CNT_W-1:0]   cnt_new, zero_new;
    logic [SUM_W-1:0]   sum_new;
    logic [CMP_W-1:0]   ppr_ext, round_len;
    logic               round_end;
    logic [CNT_W-1:0]   divisor_cnt;
    logic [DIST_W-1:0]  span_eff;
    logic               active;
    logic               div_start;
    logic [SUM_W-1:0]   div_a, div_b;
    logic               div_done;
    logic [SUM_W-1:0]   div_q;

    plne_div #(
        .W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign ping_ch.ready = (state_reg == S_IDLE);
    assign accept        = ping_ch.valid && ping_ch.ready;
    assign out_free      = !out_valid_reg || note_ch.ready;

    assign note_ch.valid     = out_valid_reg;
    assign note_ch.note_on   = out_on_reg;
    assign note_ch.octave    = out_oct_reg;
    assign note_ch.final_res = out_final_reg;

    always_comb
    begin
        cnt_new   = cnt_reg + 1'b1;
        zero_new  = zero_reg + CNT_W'(ping_ch.echo_range == '0);
        sum_new   = sum_reg + SUM_W'(ping_ch.echo_range);
        ppr_ext   = CMP_W'(cfg.pings_per_round);
        if (ppr_ext == '0)
        begin
            round_len = CMP_W'(1);
        end
        else if (ppr_ext > CMP_W'(MAX_ROUNDS))
        begin
            round_len = CMP_W'(MAX_ROUNDS);
        end
        else
        begin
            round_len = ppr_ext;
        end
        round_end   = (CMP_W'(cnt_new) >= round_len);
        divisor_cnt = (zero_new < cnt_new) ? CNT_W'(cnt_new - zero_new) : CNT_W'(1);
        span_eff    = (cfg.octave_span == '0) ? DIST_W'(1) : cfg.octave_span;
        active      = ping_act_reg || light_act_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        zero_next       = zero_reg;
        sum_next        = sum_reg;
        was_active_next = was_active_reg;
        last_oct_next   = last_oct_reg;
        light_act_next  = light_act_reg;
        ping_act_next   = ping_act_reg;
        oct_next        = oct_reg;
        ev_cnt_next     = ev_cnt_reg;
        ev0_on_next     = ev0_on_reg;
        ev0_oct_next    = ev0_oct_reg;
        ev1_oct_next    = ev1_oct_reg;
        out_valid_next  = out_valid_reg && !note_ch.ready;
        out_on_next     = out_on_reg;
        out_oct_next    = out_oct_reg;
        out_final_next  = out_final_reg;
        div_start       = 1'b0;
        div_a           = sum_new;
        div_b           = SUM_W'(divisor_cnt);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (round_end)
                    begin
                        div_start      = 1'b1;
                        light_act_next = ({1'b0, ~ping_ch.light_raw} > cfg.light_threshold);
                        cnt_next       = '0;
                        zero_next      = '0;
                        sum_next       = '0;
                        state_next     = S_AVG;
                    end
                    else
                    begin
                        cnt_next  = cnt_new;
                        zero_next = zero_new;
                        sum_next  = sum_new;
                    end
                end
            end
            S_AVG:
            begin
                if (div_done)
                begin
                    ping_act_next = (div_q >= SUM_W'(cfg.min_distance)) &&
                                    (PRD_W'(div_q) * PRD_W'(5) <=
                                     PRD_W'(cfg.max_distance) * PRD_W'(3));
                    if (div_q == '0)
                    begin
                        oct_next   = last_oct_reg;
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_a      = div_q - 1'b1;
                        div_b      = SUM_W'(span_eff);
                        state_next = S_OCT;
                    end
                end
            end
            S_OCT:
            begin
                if (div_done)
                begin
                    oct_next   = (div_q > SUM_W'(OCTAVE_CAP)) ? OCTAVE_CAP : LAST_W'(div_q);
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ev_cnt_next  = 2'd0;
                ev0_oct_next = oct_reg[OCT_W-1:0];
                ev1_oct_next = last_oct_reg[OCT_W-1:0];
                if (active)
                begin
                    if (!was_active_reg || oct_reg != last_oct_reg)
                    begin
                        ev0_on_next   = 1'b1;
                        ev_cnt_next   = (was_active_reg && last_oct_reg != NO_OCTAVE &&
                                         oct_reg != last_oct_reg) ? 2'd2 : 2'd1;
                        last_oct_next = oct_reg;
                    end
                end
                else if (was_active_reg)
                begin
                    ev0_on_next = 1'b0;
                    ev_cnt_next = 2'd1;
                end
                was_active_next = active;
                if (ev_cnt_next == 2'd0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT0;
                end
            end
            S_EMIT0:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_on_next    = ev0_on_reg;
                    out_oct_next   = ev0_oct_reg;
                    out_final_next = (ev_cnt_reg == 2'd1);
                    state_next     = (ev_cnt_reg == 2'd1) ? S_IDLE : S_EMIT1;
                end
            end
            S_EMIT1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_on_next    = 1'b0;
                    out_oct_next   = ev1_oct_reg;
                    out_final_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            zero_reg       <= '0;
            sum_reg        <= '0;
            was_active_reg <= 1'b0;
            last_oct_reg   <= NO_OCTAVE;
            ev_cnt_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            zero_reg       <= zero_next;
            sum_reg        <= sum_next;
            was_active_reg <= was_active_next;
            last_oct_reg   <= last_oct_next;
            ev_cnt_reg     <= ev_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        light_act_reg <= light_act_next;
        ping_act_reg  <= ping_act_next;
        oct_reg       <= oct_next;
        ev0_on_reg    <= ev0_on_next;
        ev0_oct_reg   <= ev0_oct_next;
        ev1_oct_reg   <= ev1_oct_next;
        out_on_reg    <= out_on_next;
        out_oct_reg   <= out_oct_next;
        out_final_reg <= out_final_next;
    end

    `PLNE_ASSERT_NOW(a_cnt_in_round, clk, rst_n, 1'b1, cnt_reg < CNT_W'(MAX_ROUNDS), "ping count reached round bound while idle")
    `PLNE_ASSERT_NOW(a_div_done_state, clk, rst_n, div_done, state_reg == S_AVG || state_reg == S_OCT, "divider finished outside a division step")
    `PLNE_ASSERT_NOW(a_second_event, clk, rst_n, state_reg == S_EMIT1, ev_cnt_reg == 2'd2, "second event slot used with one event pending")
    `PLNE_ASSERT_NEXT(a_eval_clears_round, clk, rst_n, state_reg == S_EVAL, cnt_reg == '0 && sum_reg == '0, "round counters not cleared after round end")

endmodule

// ----- hw/rtl/plne_cfg.sv -----
// ----------------------------------------------------------------------------
// plne_cfg
// Configuration register file with reset values, write-only.
// ----------------------------------------------------------------------------
module plne_cfg
    import plne_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_PINGS_PER_ROUND: cfg_next.pings_per_round = cfg_wdata[PPR_W-1:0];
                REG_MIN_DISTANCE:    cfg_next.min_distance    = cfg_wdata[DIST_W-1:0];
                REG_MAX_DISTANCE:    cfg_next.max_distance    = cfg_wdata[DIST_W-1:0];
                REG_OCTAVE_SPAN:     cfg_next.octave_span     = cfg_wdata[DIST_W-1:0];
                REG_LIGHT_THRESHOLD: cfg_next.light_threshold = cfg_wdata[THR_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pings_per_round <= PPR_W'(5);
            cfg_reg.min_distance    <= DIST_W'(5);
            cfg_reg.max_distance    <= DIST_W'(100);
            cfg_reg.octave_span     <= DIST_W'(19);
            cfg_reg.light_threshold <= THR_W'(1023);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/plne_div.sv -----
// ----------------------------------------------------------------------------
// plne_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plne_div
    import plne_pkg::*;
#(
    parameter int W = 14
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [W:0]       trial;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[W-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? W'(trial - {1'b0, dsr_reg}) : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
